// ===== design/palc_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyline arc-length locator package
// Beat types, request and status codes, and sizing constants shared by the core.
// ----------------------------------------------------------------------------
package palc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int COORD_W      = 32;
    localparam int LEN_W        = 40;
    localparam int TOL_W        = 16;
    localparam int ROOT_W       = COORD_W + 1;
    localparam int ROOT_STEPS   = ROOT_W;
    localparam int MUL_STEPS    = COORD_W;
    localparam int PROD_W       = LEN_W + COORD_W;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_LOCATE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BEYOND   = 2'd1,
        ST_TOO_FEW  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [LEN_W-1:0]          arc_distance;
    } t_req_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [LEN_W-1:0]          curve_length;
        logic [CNT_W-1:0]          vertex_total;
        logic [1:0]                status;
    } t_rsp_beat;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   seg;
    } t_vtx_entry;

endpackage

// ===== design/polyline_arc_length_locator_core.sv =====
// ----------------------------------------------------------------------------
// Polyline arc-length locator core
// Stores a 2-D polyline and finds the point at a given distance along it.
// ----------------------------------------------------------------------------
// Usage: a request beat on i_req (valid/ready) carries a clear, append or
// locate command; exactly one response beat per request comes out on o_rsp
// (valid/ready). i_cfg_we and i_cfg_wdata write the end tolerance register;
// the user must do so only while no request is in flight; the core has no guard.
// Sequencing: clear, unused codes, a full store and a locate on fewer than two
// vertices answer in the cycle after acceptance, as does appending the first
// vertex. Any later append runs two 32x32 squarings, one add, then 33 steps of
// the bit-pair square root. A locate reads entry zero, then walks the segments
// at one vertex memory read per cycle; when it lands inside a segment of
// nonzero length it runs, per axis, 32 shift-add multiply steps then 32
// restoring divide steps.
// Throughput: one request at a time; o_req_ready is high only when the
// sequencer is idle and the response register is empty, so a stalled
// receiver holds off the next request. The response beat stays unchanged
// until it is taken.
// Reset (synchronous, active low) empties the polyline, zeroes the total
// length and sets the end tolerance to one. The vertex memory is not cleared;
// only entries below the vertex count are ever used.
// ----------------------------------------------------------------------------
module polyline_arc_length_locator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  palc_pkg::t_req_beat   i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output palc_pkg::t_rsp_beat   o_rsp,
    input  logic                  i_cfg_we,
    input  logic [palc_pkg::TOL_W-1:0] i_cfg_wdata
);
    import palc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SQX   = 10'b0000000010,
        S_SQY   = 10'b0000000100,
        S_SUM   = 10'b0000001000,
        S_ROOT  = 10'b0000010000,
        S_FILL  = 10'b0000100000,
        S_FIRST = 10'b0001000000,
        S_WALK  = 10'b0010000000,
        S_MUL   = 10'b0100000000,
        S_DIV   = 10'b1000000000
    } t_state;

    t_state             r_state;
    t_req_beat          r_req;
    t_rsp_beat          r_rsp;
    logic               r_rsp_valid;

    // Vertex memory: one entry per vertex holds its coordinates and the length
    // of the segment that ends at it.
    t_vtx_entry         r_mem [MAX_VERTICES];
    t_vtx_entry         r_rdata;
    logic [ADDR_W-1:0]  r_rd_ptr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_vtx_entry         w_wdata;

    logic [CNT_W-1:0]   r_cnt;
    logic [LEN_W-1:0]   r_total;
    logic [TOL_W-1:0]   r_tol;
    logic [COORD_W-1:0] r_last_x;
    logic [COORD_W-1:0] r_last_y;

    // Square root datapath.
    logic [COORD_W-1:0]   r_ax;
    logic [COORD_W-1:0]   r_ay;
    logic [2*COORD_W-1:0] r_sqx;
    logic [2*COORD_W-1:0] r_sqy;
    logic [2*ROOT_W-1:0]  r_rad;
    logic [ROOT_W+2:0]    r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [5:0]           r_step;

    // Walk and interpolation datapath.
    logic [ADDR_W-1:0]  r_idx;
    logic [LEN_W-1:0]   r_cum;
    logic [COORD_W-1:0] r_prev_x;
    logic [COORD_W-1:0] r_prev_y;
    logic [COORD_W-1:0] r_end_x;
    logic [COORD_W-1:0] r_end_y;
    logic               r_neg_x;
    logic               r_neg_y;
    logic [COORD_W-1:0] r_mag_y;
    logic [LEN_W-1:0]   r_back;
    logic [LEN_W-1:0]   r_seg;
    logic               r_axis;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_mcand;
    logic [COORD_W-1:0] r_mplier;
    logic [LEN_W-1:0]   r_drem;
    logic [COORD_W-1:0] r_quot;
    logic [COORD_W-1:0] r_px;

    logic               w_req_fire;
    logic [COORD_W:0]   w_dx_in;
    logic [COORD_W:0]   w_dy_in;

    logic [ROOT_W+2:0]  w_rem_sh;
    logic [ROOT_W+2:0]  w_trial;
    logic               w_root_ge;
    logic [ROOT_W+2:0]  n_rem;
    logic [ROOT_W-1:0]  n_root;
    logic [LEN_W:0]     w_tot_sum;
    logic [LEN_W-1:0]   n_total;

    logic [LEN_W:0]     w_cum_sum;
    logic [LEN_W-1:0]   n_cum;
    logic               w_found;
    logic [COORD_W:0]   w_dx_seg;
    logic [COORD_W:0]   w_dy_seg;
    logic [COORD_W-1:0] w_mag_x;
    logic [COORD_W-1:0] w_mag_y;
    logic [LEN_W-1:0]   w_over;

    logic [PROD_W-1:0]  n_prod;
    logic [LEN_W:0]     w_drem_sh;
    logic               w_div_ge;
    logic [LEN_W:0]     w_drem_sub;
    logic [LEN_W-1:0]   n_drem;
    logic [COORD_W-1:0] n_quot;
    logic [COORD_W-1:0] w_coord;

    assign o_req_ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign w_req_fire  = i_req_valid && o_req_ready;

    // Append: signed difference from the previous vertex on each axis.
    always_comb begin
        w_dx_in = {i_req.vertex_x[COORD_W-1], i_req.vertex_x} - {r_last_x[COORD_W-1], r_last_x};
        w_dy_in = {i_req.vertex_y[COORD_W-1], i_req.vertex_y} - {r_last_y[COORD_W-1], r_last_y};
    end

    // One step of the bit-pair square root, and the saturating new total length.
    always_comb begin
        w_rem_sh  = {r_rem[ROOT_W:0], r_rad[2*ROOT_W-1 -: 2]};
        w_trial   = {1'b0, r_root, 2'b01};
        w_root_ge = (w_rem_sh >= w_trial);
        n_rem     = w_root_ge ? (w_rem_sh - w_trial) : w_rem_sh;
        n_root    = {r_root[ROOT_W-2:0], w_root_ge};
        w_tot_sum = {1'b0, r_total} + {{(LEN_W-ROOT_W+1){1'b0}}, n_root};
        n_total   = w_tot_sum[LEN_W] ? LEN_MAX : w_tot_sum[LEN_W-1:0];
    end

    // Walk: saturating running sum and the segment vector of the hit.
    always_comb begin
        w_cum_sum = {1'b0, r_cum} + {1'b0, r_rdata.seg};
        n_cum     = w_cum_sum[LEN_W] ? LEN_MAX : w_cum_sum[LEN_W-1:0];
        w_found   = (n_cum >= r_req.arc_distance);
        w_dx_seg  = {r_rdata.x[COORD_W-1], r_rdata.x} - {r_prev_x[COORD_W-1], r_prev_x};
        w_dy_seg  = {r_rdata.y[COORD_W-1], r_rdata.y} - {r_prev_y[COORD_W-1], r_prev_y};
        w_mag_x   = w_dx_seg[COORD_W] ? COORD_W'(-w_dx_seg) : w_dx_seg[COORD_W-1:0];
        w_mag_y   = w_dy_seg[COORD_W] ? COORD_W'(-w_dy_seg) : w_dy_seg[COORD_W-1:0];
        w_over    = r_req.arc_distance - n_cum;
    end

    // Shift-add multiply and restoring divide, shared by both axes.
    always_comb begin
        n_prod     = r_mplier[0] ? (r_prod + r_mcand) : r_prod;
        w_drem_sh  = {r_drem, r_prod[COORD_W-1]};
        w_div_ge   = (w_drem_sh >= {1'b0, r_seg});
        w_drem_sub = w_drem_sh - {1'b0, r_seg};
        n_drem     = w_div_ge ? w_drem_sub[LEN_W-1:0] : w_drem_sh[LEN_W-1:0];
        n_quot     = {r_quot[COORD_W-2:0], w_div_ge};
        // The offset moves the end point back toward the segment start.
        if (r_axis) begin
            w_coord = r_neg_y ? (r_end_y + n_quot) : (r_end_y - n_quot);
        end else begin
            w_coord = r_neg_x ? (r_end_x + n_quot) : (r_end_x - n_quot);
        end
    end

    // Memory write: the first vertex goes in at once, later ones after the root.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[ADDR_W-1:0];
        w_wdata = '{x: r_req.vertex_x, y: r_req.vertex_y,
                    seg: {{(LEN_W-ROOT_W){1'b0}}, n_root}};
        if (r_state == S_IDLE) begin
            w_we    = w_req_fire && (i_req.req_type == REQ_APPEND) && (r_cnt == '0);
            w_waddr = '0;
            w_wdata = '{x: i_req.vertex_x, y: i_req.vertex_y, seg: '0};
        end else if (r_state == S_ROOT) begin
            w_we = (r_step == 6'(ROOT_STEPS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_tol       <= TOL_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (r_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_req_fire) begin
                        r_req <= i_req;
                        r_rsp <= '{point_x: '0, point_y: '0, curve_length: r_total,
                                   vertex_total: r_cnt, status: ST_OK};
                        case (i_req.req_type)
                            REQ_CLEAR: begin
                                r_cnt             <= '0;
                                r_total           <= '0;
                                r_rsp.curve_length <= '0;
                                r_rsp.vertex_total <= '0;
                                r_rsp_valid       <= 1'b1;
                            end
                            REQ_APPEND: begin
                                if (r_cnt == CNT_W'(MAX_VERTICES)) begin
                                    r_rsp.status <= ST_FULL;
                                    r_rsp_valid  <= 1'b1;
                                end else if (r_cnt == '0) begin
                                    r_cnt              <= CNT_W'(1);
                                    r_last_x           <= i_req.vertex_x;
                                    r_last_y           <= i_req.vertex_y;
                                    r_rsp.vertex_total <= CNT_W'(1);
                                    r_rsp_valid        <= 1'b1;
                                end else begin
                                    r_ax    <= w_dx_in[COORD_W] ? COORD_W'(-w_dx_in)
                                                                : w_dx_in[COORD_W-1:0];
                                    r_ay    <= w_dy_in[COORD_W] ? COORD_W'(-w_dy_in)
                                                                : w_dy_in[COORD_W-1:0];
                                    r_state <= S_SQX;
                                end
                            end
                            REQ_LOCATE: begin
                                if (r_cnt < CNT_W'(2)) begin
                                    r_rsp.status <= ST_TOO_FEW;
                                    r_rsp_valid  <= 1'b1;
                                end else begin
                                    r_rd_ptr <= '0;
                                    r_state  <= S_FILL;
                                end
                            end
                            default: begin
                                r_rsp_valid <= 1'b1;
                            end
                        endcase
                    end
                end

                S_SQX: begin
                    r_sqx   <= r_ax * r_ax;
                    r_state <= S_SQY;
                end

                S_SQY: begin
                    r_sqy   <= r_ay * r_ay;
                    r_state <= S_SUM;
                end

                S_SUM: begin
                    r_rad   <= {2'b00, r_sqx} + {2'b00, r_sqy};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end

                S_ROOT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= {r_rad[2*ROOT_W-3:0], 2'b00};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(ROOT_STEPS - 1)) begin
                        r_cnt              <= r_cnt + CNT_W'(1);
                        r_total            <= n_total;
                        r_last_x           <= r_req.vertex_x;
                        r_last_y           <= r_req.vertex_y;
                        r_rsp.curve_length <= n_total;
                        r_rsp.vertex_total <= r_cnt + CNT_W'(1);
                        r_rsp_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end

                S_FILL: begin
                    r_rd_ptr <= ADDR_W'(1);
                    r_state  <= S_FIRST;
                end

                S_FIRST: begin
                    // Entry zero is the start of the first segment.
                    r_prev_x <= r_rdata.x;
                    r_prev_y <= r_rdata.y;
                    r_cum    <= '0;
                    r_idx    <= ADDR_W'(1);
                    r_rd_ptr <= ADDR_W'(2);
                    r_state  <= S_WALK;
                end

                S_WALK: begin
                    if (w_found) begin
                        if (r_rdata.seg == '0) begin
                            r_rsp.point_x <= r_rdata.x;
                            r_rsp.point_y <= r_rdata.y;
                            r_rsp_valid   <= 1'b1;
                            r_state       <= S_IDLE;
                        end else begin
                            r_end_x  <= r_rdata.x;
                            r_end_y  <= r_rdata.y;
                            r_neg_x  <= w_dx_seg[COORD_W];
                            r_neg_y  <= w_dy_seg[COORD_W];
                            r_mag_y  <= w_mag_y;
                            r_back   <= n_cum - r_req.arc_distance;
                            r_seg    <= r_rdata.seg;
                            r_axis   <= 1'b0;
                            r_prod   <= '0;
                            r_mcand  <= {{COORD_W{1'b0}}, n_cum - r_req.arc_distance};
                            r_mplier <= w_mag_x;
                            r_step   <= '0;
                            r_state  <= S_MUL;
                        end
                    end else if ({1'b0, r_idx} == r_cnt - CNT_W'(1)) begin
                        // Past the last vertex: accept it within the tolerance.
                        if (w_over < {{(LEN_W-TOL_W){1'b0}}, r_tol}) begin
                            r_rsp.point_x <= r_rdata.x;
                            r_rsp.point_y <= r_rdata.y;
                        end else begin
                            r_rsp.status <= ST_BEYOND;
                        end
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_prev_x <= r_rdata.x;
                        r_prev_y <= r_rdata.y;
                        r_cum    <= n_cum;
                        r_idx    <= r_idx + ADDR_W'(1);
                        r_rd_ptr <= r_rd_ptr + ADDR_W'(1);
                    end
                end

                S_MUL: begin
                    r_prod   <= n_prod;
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[COORD_W-1:1]};
                    r_step   <= r_step + 6'd1;
                    if (r_step == 6'(MUL_STEPS - 1)) begin
                        // The quotient fits in 32 bits, so the upper product
                        // bits already sit below the divisor.
                        r_drem  <= n_prod[PROD_W-1:COORD_W];
                        r_quot  <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_drem <= n_drem;
                    r_quot <= n_quot;
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(MUL_STEPS - 1)) begin
                        if (!r_axis) begin
                            r_px     <= w_coord;
                            r_axis   <= 1'b1;
                            r_prod   <= '0;
                            r_mcand  <= {{COORD_W{1'b0}}, r_back};
                            r_mplier <= r_mag_y;
                            r_step   <= '0;
                            r_state  <= S_MUL;
                        end else begin
                            r_rsp.point_x <= r_px;
                            r_rsp.point_y <= w_coord;
                            r_rsp_valid   <= 1'b1;
                            r_state       <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/polyline_locate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline locator response checker
// Watches the request, response and tolerance ports of the locator core,
// keeps its own copy of the polyline and predicts every response beat.
// ----------------------------------------------------------------------------
module polyline_locate_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  palc_pkg::t_req_beat         i_req,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  palc_pkg::t_rsp_beat         i_rsp,
    input  logic                        i_cfg_we,
    input  logic [palc_pkg::TOL_W-1:0]  i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_vertex_count,
    output logic [palc_pkg::LEN_W-1:0]  o_curve_length,
    output int                          o_rsp_seen,
    output int                          o_beyond_seen,
    output int                          o_full_seen
);
    import palc_pkg::*;

    logic [COORD_W-1:0] x_mem [MAX_VERTICES];
    logic [COORD_W-1:0] y_mem [MAX_VERTICES];
    logic [LEN_W-1:0]   seg_mem [MAX_VERTICES];
    int                 vtx_count;
    logic [LEN_W-1:0]   total_len;
    logic [TOL_W-1:0]   tolerance;
    t_rsp_beat          expected_rsp_q [$];

    assign o_vertex_count = vtx_count;
    assign o_curve_length = total_len;

    function automatic logic [32:0] floor_sqrt(logic [65:0] v);
        logic [32:0] root;
        logic [32:0] trial;
        root = '0;
        for (int b = 32; b >= 0; b--) begin
            trial = root | (33'd1 << b);
            if ({35'd0, trial} * {35'd0, trial} <= {2'd0, v}) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Moves the end coordinate back toward the segment start by
    // floor(back * |delta| / seg), so the point is rounded toward the end.
    function automatic logic [COORD_W-1:0] pull_back(logic signed [63:0] endc,
            logic signed [63:0] delta, logic [63:0] back, logic [LEN_W-1:0] seg);
        logic [79:0] prod;
        logic [63:0] mag;
        logic [63:0] off;
        mag  = (delta < 0) ? -delta : delta;
        prod = {16'd0, back} * {16'd0, mag};
        off  = 64'(prod / {40'd0, seg});
        return (delta >= 0) ? COORD_W'(endc - $signed(off)) : COORD_W'(endc + $signed(off));
    endfunction

    function automatic t_rsp_beat predict_response(t_req_beat b);
        t_rsp_beat        r;
        logic [63:0]      ax;
        logic [63:0]      ay;
        logic [65:0]      sq;
        logic [LEN_W-1:0] seg;
        logic [63:0]      cum;
        logic [63:0]      sum;
        logic signed [63:0] ex;
        logic signed [63:0] ey;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        bit               found;
        r = '0;
        r.status = ST_OK;
        case (b.req_type)
            REQ_CLEAR: begin
                vtx_count = 0;
                total_len = '0;
            end
            REQ_APPEND: begin
                if (vtx_count >= MAX_VERTICES) begin
                    r.status = ST_FULL;
                end else begin
                    seg = '0;
                    x_mem[vtx_count] = b.vertex_x;
                    y_mem[vtx_count] = b.vertex_y;
                    if (vtx_count > 0) begin
                        sx = 64'($signed(b.vertex_x)) - 64'($signed(x_mem[vtx_count-1]));
                        sy = 64'($signed(b.vertex_y)) - 64'($signed(y_mem[vtx_count-1]));
                        ax = (sx < 0) ? -sx : sx;
                        ay = (sy < 0) ? -sy : sy;
                        sq = {2'd0, ax} * {2'd0, ax} + {2'd0, ay} * {2'd0, ay};
                        seg = LEN_W'(floor_sqrt(sq));
                        sum = {24'd0, total_len} + {24'd0, seg};
                        total_len = (sum > {24'd0, LEN_MAX}) ? LEN_MAX : sum[LEN_W-1:0];
                    end
                    seg_mem[vtx_count] = seg;
                    vtx_count++;
                end
            end
            REQ_LOCATE: begin
                if (vtx_count < 2) begin
                    r.status = ST_TOO_FEW;
                end else begin
                    cum   = '0;
                    found = 0;
                    for (int i = 1; i < vtx_count && !found; i++) begin
                        cum = cum + {24'd0, seg_mem[i]};
                        if (cum > {24'd0, LEN_MAX}) cum = {24'd0, LEN_MAX};
                        if (cum >= {24'd0, b.arc_distance}) begin
                            found = 1;
                            ex = 64'($signed(x_mem[i]));
                            ey = 64'($signed(y_mem[i]));
                            if (seg_mem[i] == '0) begin
                                r.point_x = x_mem[i];
                                r.point_y = y_mem[i];
                            end else begin
                                r.point_x = pull_back(ex, ex - 64'($signed(x_mem[i-1])),
                                    cum - {24'd0, b.arc_distance}, seg_mem[i]);
                                r.point_y = pull_back(ey, ey - 64'($signed(y_mem[i-1])),
                                    cum - {24'd0, b.arc_distance}, seg_mem[i]);
                            end
                        end
                    end
                    if (!found) begin
                        if ({24'd0, b.arc_distance} - cum < {48'd0, tolerance}) begin
                            r.point_x = x_mem[vtx_count-1];
                            r.point_y = y_mem[vtx_count-1];
                        end else begin
                            r.status = ST_BEYOND;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.curve_length = total_len;
        r.vertex_total = CNT_W'(vtx_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp_beat want;
        if (!i_rst_n) begin
            vtx_count = 0;
            total_len = '0;
            tolerance = TOL_W'(1);
            expected_rsp_q.delete();
            o_fail_count  <= 0;
            o_pending     <= 0;
            o_rsp_seen    <= 0;
            o_beyond_seen <= 0;
            o_full_seen   <= 0;
        end else begin
            if (i_cfg_we) begin
                tolerance = i_cfg_wdata;
            end
            if (i_req_valid && i_req_ready) begin
                expected_rsp_q.push_back(predict_response(i_req));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                o_rsp_seen <= o_rsp_seen + 1;
                if (i_rsp.status == ST_BEYOND) o_beyond_seen <= o_beyond_seen + 1;
                if (i_rsp.status == ST_FULL) o_full_seen <= o_full_seen + 1;
                if (expected_rsp_q.size() == 0) begin
                    $error("response beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_rsp.point_x !== want.point_x)
                            $error("point_x expected %h got %h", want.point_x, i_rsp.point_x);
                        if (i_rsp.point_y !== want.point_y)
                            $error("point_y expected %h got %h", want.point_y, i_rsp.point_y);
                        if (i_rsp.curve_length !== want.curve_length)
                            $error("curve_length expected %h got %h",
                                want.curve_length, i_rsp.curve_length);
                        if (i_rsp.vertex_total !== want.vertex_total)
                            $error("vertex_total expected %0d got %0d",
                                want.vertex_total, i_rsp.vertex_total);
                        if (i_rsp.status !== want.status)
                            $error("status expected %0d got %0d", want.status, i_rsp.status);
                    end
                end
            end
            o_pending <= expected_rsp_q.size();
        end
    end

endmodule

// ===== sim/polyline_arc_length_locator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline arc-length locator core testbench
// Drives clear, append, locate and unused-code beats with random gaps and
// back-pressure, rewrites the end tolerance between phases and lets a checker
// compare every response beat against its own prediction.
// ----------------------------------------------------------------------------
module polyline_arc_length_locator_core_test;
    import palc_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int PHASE_BEATS     = 240;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_req_valid = 1'b0;
    logic             o_req_ready;
    t_req_beat        i_req = '0;
    logic             o_rsp_valid;
    logic             i_rsp_ready = 1'b0;
    t_rsp_beat        o_rsp;
    logic             i_cfg_we = 1'b0;
    logic [TOL_W-1:0] i_cfg_wdata = '0;

    int               fail_count;
    int               pending;
    int               model_vertices;
    logic [LEN_W-1:0] model_length;
    int               rsp_seen;
    int               beyond_seen;
    int               full_seen;

    // Idle percentages for the two sides; changed from phase to phase.
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               beats_sent = 0;
    int               quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    polyline_arc_length_locator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    polyline_locate_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .i_req_ready    (o_req_ready),
        .i_req          (i_req),
        .i_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .i_rsp          (o_rsp),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_vertex_count (model_vertices),
        .o_curve_length (model_length),
        .o_rsp_seen     (rsp_seen),
        .o_beyond_seen  (beyond_seen),
        .o_full_seen    (full_seen)
    );

    // The receiver drops ready at random, once per cycle, so responses wait in the
    // core's response register and hold off its next request.
    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The watchdog only counts cycles in which neither channel moves a beat.
    // The slowest locate plus a long receiver stall stays far below the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("polyline_arc_length_locator_core_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one request beat. It is entered and left at a rising edge; ready
    // is looked at on the falling edge, where it is stable, and the beat is
    // accepted at the rising edge that follows.
    task automatic send_beat(input logic [1:0] kind, input logic [31:0] vx,
            input logic [31:0] vy, input logic [LEN_W-1:0] distance);
        t_req_beat b;
        b.req_type     = kind;
        b.vertex_x     = vx;
        b.vertex_y     = vy;
        b.arc_distance = distance;
        if ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= b;
        @(negedge i_clk);
        while (!o_req_ready) @(negedge i_clk);
        @(posedge i_clk);
        beats_sent++;
    endtask

    // Holds the sender back until every expected response has come, then lets
    // the clock run on so the sequencer is surely idle.
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] random_len40();
        return {8'($urandom_range(255)), $urandom};
    endfunction

    // Picks a locate distance around the current curve: the start, the end,
    // just past the end, inside the curve, or anywhere in the 40-bit range.
    function automatic logic [LEN_W-1:0] pick_distance(input logic [LEN_W-1:0] len);
        logic [71:0] scaled;
        case ($urandom_range(7))
            0: return '0;
            1: return len;
            2: return len + LEN_W'($urandom_range(70000));
            3: return random_len40();
            default: begin
                scaled = {32'd0, len} * {40'd0, $urandom};
                return scaled[71:32];
            end
        endcase
    endfunction

    // Small coordinates keep segments short enough for many locates to land
    // inside them; full-range ones exercise every bit and the wide square root.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
            default: return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    // A long zigzag between opposite corners saturates the total length,
    // then fills the store so further appends are refused.
    task automatic fill_to_saturation();
        send_beat(REQ_CLEAR, 32'd0, 32'd0, '0);
        for (int i = 0; i < MAX_VERTICES + 3; i++) begin
            if (i[0]) send_beat(REQ_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
            else      send_beat(REQ_APPEND, 32'h8000_0000, 32'h8000_0000, '0);
        end
        send_beat(REQ_LOCATE, '0, '0, LEN_MAX);
        send_beat(REQ_LOCATE, '0, '0, LEN_MAX - 40'd1);
        send_beat(REQ_LOCATE, '0, '0, random_len40());
        send_beat(REQ_LOCATE, '0, '0, '0);
    endtask

    // One random polyline sequence: mostly a clear, a handful of appends
    // (some repeating the last vertex to make zero-length segments) and a
    // few locates; now and then a stray beat of any code instead.
    task automatic random_sequence();
        logic [31:0] lx;
        logic [31:0] ly;
        int          n;
        lx = pick_coord();
        ly = pick_coord();
        if ($urandom_range(99) < 6) begin
            send_beat(2'($urandom_range(3)), $urandom, $urandom, random_len40());
        end else begin
            if ($urandom_range(99) < 85 || model_vertices > MAX_VERTICES - 20) begin
                send_beat(REQ_CLEAR, $urandom, $urandom, random_len40());
            end
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(99) >= 12) begin
                    lx = pick_coord();
                    ly = pick_coord();
                end
                send_beat(REQ_APPEND, lx, ly, random_len40());
            end
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                send_beat(REQ_LOCATE, $urandom, $urandom, pick_distance(model_length));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the reset tolerance of one: too few vertices,
        // a zero-length segment, a 3-4-5 segment, the widest possible
        // segment, the exact end, one past it, the top of the distance
        // range, and the unused request code with every field bit set.
        send_beat(REQ_CLEAR, '0, '0, '0);
        send_beat(REQ_LOCATE, '0, '0, '0);
        send_beat(REQ_APPEND, '0, '0, '0);
        send_beat(REQ_LOCATE, '0, '0, '0);
        send_beat(REQ_APPEND, '0, '0, '0);
        send_beat(REQ_APPEND, 32'h0003_0000, 32'h0004_0000, '0);
        send_beat(REQ_LOCATE, '0, '0, 40'h0_0000_8000);
        send_beat(REQ_LOCATE, '0, '0, 40'h0_0002_8000);
        send_beat(REQ_APPEND, 32'h8000_0000, 32'h8000_0000, '0);
        send_beat(REQ_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        send_beat(REQ_LOCATE, '0, '0, '0);
        send_beat(REQ_LOCATE, '0, '0, model_length);
        send_beat(REQ_LOCATE, '0, '0, model_length + 40'd1);
        send_beat(REQ_LOCATE, '0, '0, model_length - 40'd12345);
        send_beat(REQ_LOCATE, '0, '0, LEN_MAX);
        send_beat(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, LEN_MAX);
        send_beat(REQ_CLEAR, '0, '0, '0);
        send_beat(REQ_LOCATE, '0, '0, '0);

        // Three phases of random traffic, each at its own tolerance and idle
        // pattern; the last one runs with no idling on either side.
        for (int phase = 0; phase < 3; phase++) begin
            drain_responses();
            case (phase)
                0: begin
                    write_tolerance('0);
                    send_idle_pct = 13;
                    recv_idle_pct = 80;
                end
                1: begin
                    write_tolerance('1);
                    send_idle_pct = 80;
                    recv_idle_pct = 13;
                end
                default: begin
                    write_tolerance(TOL_W'($urandom_range(65535)));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) fill_to_saturation();
            while (beats_sent < 18 + (phase + 1) * PHASE_BEATS + 263) random_sequence();
        end

        drain_responses();
        repeat (400) @(posedge i_clk);

        $display("Run covered %0d request beats and %0d response beats over three idle patterns,",
            beats_sent, rsp_seen);
        $display("with %0d beyond-end and %0d store-full responses among them.",
            beyond_seen, full_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("polyline_arc_length_locator_core_test: PASS");
        end else begin
            $display("polyline_arc_length_locator_core_test: FAIL");
        end
        $finish;
    end

endmodule
